// ===== design/dopq_pkg.sv =====
// Shared definitions for the drop-oldest packet ring queue.
// Holds default sizes, item kind codes and the controller state type; no dependencies.
`default_nettype none

package dopq_pkg;

  localparam int DEF_QUEUE_SLOTS = 8;
  localparam int DEF_SLOT_BYTES  = 128;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// ===== design/dopq_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Stand-alone; used for the packet byte store and the slot length store.
`default_nettype none

module dopq_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/dopq_ctrl.sv =====
// Queue controller: slot pointers, offsets, packet count, pop sequencer and result register.
// Uses dopq_pkg; drives the byte and length RAMs held in the top level.
`default_nettype none

module dopq_ctrl
  import dopq_pkg::*;
#(
  parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
  parameter int SLOT_BYTES  = DEF_SLOT_BYTES,
  localparam int SW = $clog2(QUEUE_SLOTS),
  localparam int CW = $clog2(QUEUE_SLOTS + 1),
  localparam int LW = $clog2(SLOT_BYTES + 1),
  localparam int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_packet,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [7:0]         read_byte,
  output logic                    last_of_packet,
  output logic                    was_empty,
  output logic      [3:0]         packets_stored,
  output logic                    rd_en,
  output logic                    bw_en,
  output logic      [SW+OW-1:0]   bw_addr,
  output logic      [7:0]         bw_data,
  output logic      [SW+OW-1:0]   br_addr,
  input  wire logic [7:0]         br_data,
  output logic                    lw_en,
  output logic      [SW-1:0]      lw_addr,
  output logic      [LW-1:0]      lw_data,
  output logic      [SW-1:0]      lr_addr,
  input  wire logic [LW-1:0]      lr_data
);

  state_t state, state_next;

  logic [SW-1:0] head, head_next;
  logic [SW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [LW-1:0] write_offset, write_offset_next;
  logic [LW-1:0] read_offset, read_offset_next;

  logic          push_acc, pop_acc;
  logic          full_drop, wr_ok, empty, last;
  logic [LW-1:0] wo_inc;
  logic [CW+3:0] cnt_ext;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(QUEUE_SLOTS - 1)) ? '0 : s + SW'(1);
  endfunction

  // pushes are never held back by a waiting result; pops need the result slot
  assign in_ready = (state == ST_IDLE) && ((kind == KIND_PUSH) || !out_valid || out_ready);
  assign push_acc = in_valid && in_ready && (kind == KIND_PUSH);
  assign pop_acc  = in_valid && in_ready && (kind == KIND_POP);

  assign full_drop = (write_offset == '0) && (count == CW'(QUEUE_SLOTS));
  assign wr_ok     = write_offset < LW'(SLOT_BYTES);
  assign wo_inc    = write_offset + LW'(wr_ok);

  assign empty = (count == '0);
  assign last  = ({1'b0, read_offset} + (LW+1)'(1)) >= {1'b0, lr_data};

  assign bw_en   = push_acc && wr_ok;
  assign bw_addr = {tail, write_offset[OW-1:0]};
  assign bw_data = data_byte;
  assign lw_en   = push_acc && end_of_packet;
  assign lw_addr = tail;
  assign lw_data = wo_inc;
  assign rd_en   = pop_acc;
  assign br_addr = {head, read_offset[OW-1:0]};
  assign lr_addr = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop_acc) state_next = ST_READ;
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_next         = head;
    tail_next         = tail;
    count_next        = count;
    write_offset_next = write_offset;
    read_offset_next  = read_offset;
    if (push_acc) begin
      // oldest packet goes before the new one's first byte lands
      if (full_drop) begin
        head_next        = next_slot(head);
        read_offset_next = '0;
      end
      write_offset_next = wo_inc;
      if (end_of_packet) begin
        tail_next         = next_slot(tail);
        write_offset_next = '0;
      end
      count_next = count - CW'(full_drop) + CW'(end_of_packet);
    end else if (state == ST_READ && !empty) begin
      if (last) begin
        head_next        = next_slot(head);
        count_next       = count - CW'(1);
        read_offset_next = '0;
      end else begin
        read_offset_next = read_offset + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      write_offset <= '0;
      read_offset  <= '0;
    end else begin
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
      write_offset <= write_offset_next;
      read_offset  <= read_offset_next;
    end
  end

  assign cnt_ext = {4'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      read_byte      <= empty ? 8'd0 : br_data;
      last_of_packet <= !empty && last;
      was_empty      <= empty;
      packets_stored <= cnt_ext[3:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_SLOTS))
    else $error("packet count above slot count");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty queue with head and tail apart");

  a_pop_two_cycles: assert property (@(posedge clk) disable iff (rst)
    pop_acc |=> (state == ST_READ) ##1 (state == ST_IDLE && out_valid))
    else $error("pop did not complete in two cycles");

  a_rd_offset: assert property (@(posedge clk) disable iff (rst)
    read_offset < LW'(SLOT_BYTES))
    else $error("read offset beyond slot");

  a_result_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (!out_valid || out_ready))
    else $error("result overwrites a waiting beat");

endmodule

`default_nettype wire

// ===== design/drop_oldest_packet_ring_queue_core.sv =====
// Drop-oldest packet ring queue, top level.
// Uses dopq_pkg, dopq_ctrl and two dopq_ram instances (packet bytes, slot lengths).
//
// Input channel (in_valid/in_ready): each beat is one item. kind selects a push of
// data_byte into the packet being filled (end_of_packet commits it) or a pop of one
// byte of the oldest committed packet. When all slots hold packets, the first byte of
// a new packet drops the oldest one, partly read or not. Bytes past SLOT_BYTES are
// discarded and the stored length saturates.
// Output channel (out_valid/out_ready): one beat per pop, none per push, carrying the
// byte, a last-byte flag, an empty flag and the packet count after the pop.
// A push needs no wait state; a pop moves the controller into ST_READ, where the byte
// and length RAMs return registered reads, so no item is taken in the cycle after
// a pop. The pop's beat is then loaded into the result register, raising out_valid.
// Pushes are still accepted while a result beat waits; a pop is held (in_ready low)
// while the result register is full and not being taken.
// Reset (rst, synchronous) empties the queue at once; RAM contents are not cleared
// and need no clearing pass.
`default_nettype none

module drop_oldest_packet_ring_queue_core
  import dopq_pkg::*;
#(
  parameter int QUEUE_SLOTS = DEF_QUEUE_SLOTS,
  parameter int SLOT_BYTES  = DEF_SLOT_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_packet,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] read_byte,
  output logic            last_of_packet,
  output logic            was_empty,
  output logic      [3:0] packets_stored
);

  localparam int SW = $clog2(QUEUE_SLOTS);
  localparam int LW = $clog2(SLOT_BYTES + 1);
  localparam int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;

  logic             rd_en;
  logic             bw_en;
  logic [SW+OW-1:0] bw_addr, br_addr;
  logic [7:0]       bw_data, br_data;
  logic             lw_en;
  logic [SW-1:0]    lw_addr, lr_addr;
  logic [LW-1:0]    lw_data, lr_data;

  dopq_ctrl #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .SLOT_BYTES  (SLOT_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .end_of_packet  (end_of_packet),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_byte      (read_byte),
    .last_of_packet (last_of_packet),
    .was_empty      (was_empty),
    .packets_stored (packets_stored),
    .rd_en          (rd_en),
    .bw_en          (bw_en),
    .bw_addr        (bw_addr),
    .bw_data        (bw_data),
    .br_addr        (br_addr),
    .br_data        (br_data),
    .lw_en          (lw_en),
    .lw_addr        (lw_addr),
    .lw_data        (lw_data),
    .lr_addr        (lr_addr),
    .lr_data        (lr_data)
  );

  dopq_ram #(
    .AW (SW + OW),
    .DW (8)
  ) u_byte_ram (
    .clk   (clk),
    .we    (bw_en),
    .waddr (bw_addr),
    .wdata (bw_data),
    .re    (rd_en),
    .raddr (br_addr),
    .rdata (br_data)
  );

  dopq_ram #(
    .AW (SW),
    .DW (LW)
  ) u_len_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .re    (rd_en),
    .raddr (lr_addr),
    .rdata (lr_data)
  );

endmodule

`default_nettype wire
